### hw/rtl/limb_to_decimal_digits_macros.svh
// assertion macros shared by the front, queue and back rtl files
`ifndef LIMB_TO_DECIMAL_DIGITS_MACROS_SVH
`define LIMB_TO_DECIMAL_DIGITS_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ldd assertion failed");

// next-cycle implication
`define LDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ldd assertion failed");

`else

`define LDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/ldd_pkg.sv
package ldd_pkg;

    localparam int LIMB_DIGITS  = 9;
    localparam int MAX_CAPACITY = 4095;

    localparam int LIMB_W  = 30;
    localparam int DIG_W   = 4;
    localparam int IDX_W   = $clog2(LIMB_DIGITS + 1);
    localparam int CAP_W   = 12;
    localparam int CNT_W   = 13;
    localparam int CHAR_W  = 6;
    localparam int QUO_W   = LIMB_W - 3;

    // reciprocal of ten, exact for any 32-bit dividend
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = LIMB_W + 32;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam logic [CAP_W-1:0] CAP_CLAMP =
        (MAX_CAPACITY > 4095) ? 12'hFFF : CAP_W'(MAX_CAPACITY);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LIMB_DIGITS-1:0][DIG_W-1:0] t_digits;

    // one converted limb on its way to the printer
    typedef struct packed {
        t_digits          digits;   // index 0 is the most significant digit
        logic [IDX_W-1:0] start;    // first digit to print, LIMB_DIGITS means none
        logic             new_num;  // restart the count and latch capacity
        logic [CAP_W-1:0] cap;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

endpackage

### hw/rtl/ldd_front.sv
`include "limb_to_decimal_digits_macros.svh"

module ldd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ldd_pkg::LIMB_W-1:0] i_limb_value,
    input  logic                      i_first_limb,
    input  logic                      i_number_empty,
    input  logic                      i_drop_lead,
    input  logic [ldd_pkg::CAP_W-1:0] i_capacity,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output ldd_pkg::t_job             o_push_job
);
    import ldd_pkg::*;

    t_front_state      r_state, n_state;
    logic [LIMB_W-1:0] r_val;
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_lead;
    t_digits           r_digits;
    logic              r_first, r_empty, r_drop;
    logic [CAP_W-1:0]  r_cap;

    logic [PROD_W-1:0] w_prod;
    logic [QUO_W-1:0]  w_quo;
    logic [LIMB_W-1:0] w_rem;
    logic [DIG_W-1:0]  w_digit;
    logic [IDX_W-1:0]  w_start;
    logic              w_accept;

    // one decimal digit per cycle, least significant first
    always_comb begin
        w_prod  = PROD_W'(r_val) * PROD_W'(RECIP_10);
        w_quo   = w_prod[RECIP_SHIFT +: QUO_W];
        w_rem   = r_val - {w_quo, 3'b000} - {2'b00, w_quo, 1'b0};
        w_digit = w_rem[DIG_W-1:0];
    end

    // leading zeros skipped on top and empty limbs only
    always_comb begin
        if (r_empty) begin
            w_start = IDX_W'(LIMB_DIGITS - 1);
        end else if (r_first) begin
            w_start = r_lead + IDX_W'(r_drop);
        end else begin
            w_start = '0;
        end
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_push_valid       = (r_state == F_PUSH);
    assign o_push_job.digits  = r_digits;
    assign o_push_job.start   = w_start;
    assign o_push_job.new_num = r_first || r_empty;
    assign o_push_job.cap     = r_cap;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) n_state = F_CONV;
            end
            F_CONV: begin
                if (r_pos == '0) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val   <= i_number_empty ? '0 : i_limb_value;
            r_pos   <= IDX_W'(LIMB_DIGITS - 1);
            r_lead  <= IDX_W'(LIMB_DIGITS - 1);
            r_first <= i_first_limb;
            r_empty <= i_number_empty;
            r_drop  <= i_drop_lead;
            r_cap   <= (i_capacity > CAP_CLAMP) ? CAP_CLAMP : i_capacity;
        end else if (r_state == F_CONV) begin
            r_digits[r_pos] <= w_digit;
            if (w_digit != '0) r_lead <= r_pos;
            r_val <= LIMB_W'(w_quo);
            r_pos <= r_pos - 1'b1;
        end
    end

    `LDD_ASSERT_IMPLY(a_pos_range, i_clk, i_rst_n, r_state == F_CONV, r_pos < IDX_W'(LIMB_DIGITS))

endmodule

### hw/rtl/ldd_queue.sv
`include "limb_to_decimal_digits_macros.svh"

module ldd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ldd_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ldd_pkg::t_job o_pop_job
);
    import ldd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_job;
    end

    `LDD_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))
    `LDD_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, o_pop_valid)

endmodule

### hw/rtl/ldd_back.sv
`include "limb_to_decimal_digits_macros.svh"

module ldd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pop_valid,
    output logic                      o_pop_ready,
    input  ldd_pkg::t_job             i_pop_job,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ldd_pkg::CHAR_W-1:0] o_digit_char,
    output logic                      o_last_of_item
);
    import ldd_pkg::*;

    logic              r_busy;
    logic [IDX_W-1:0]  r_k;
    t_digits           r_digits;
    logic [CNT_W-1:0]  r_cnt;
    logic [CAP_W-1:0]  r_cap;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic w_load, w_slot_free, w_can_emit, w_last, w_emit;

    assign o_pop_ready = !r_busy;
    assign w_load      = i_pop_valid && o_pop_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    // a digit is left and the capacity still has room
    assign w_can_emit  = (r_k < IDX_W'(LIMB_DIGITS)) && (r_cnt < {1'b0, r_cap});
    assign w_last      = (r_k == IDX_W'(LIMB_DIGITS - 1))
                      || ((r_cnt + 1'b1) >= {1'b0, r_cap});
    assign w_emit      = r_busy && w_can_emit && w_slot_free;

    assign o_out_valid    = r_out_valid;
    assign o_digit_char   = r_out_char;
    assign o_last_of_item = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                if (i_pop_job.new_num) begin
                    r_cnt <= '0;
                    r_cap <= i_pop_job.cap;
                end
            end else if (r_busy) begin
                if (!w_can_emit) begin
                    r_busy <= 1'b0;
                end else if (w_slot_free) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) r_busy <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digits <= i_pop_job.digits;
            r_k      <= i_pop_job.start;
        end else if (w_emit) begin
            r_k <= r_k + 1'b1;
        end
        if (w_emit) begin
            r_out_char <= ASCII_ZERO + {2'b00, r_digits[r_k]};
            r_out_last <= w_last;
        end
    end

    `LDD_ASSERT_IMPLY(a_cnt_cap, i_clk, i_rst_n, r_busy, r_cnt <= {1'b0, r_cap})
    `LDD_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_load, r_busy)

endmodule

### hw/rtl/limb_to_decimal_digits.sv
// decimal printer for a base-1e9 big integer: limbs go in most significant
// first, ascii digit characters come out one per transfer. the top limb of a
// number (first_limb) prints without leading zeros, later limbs print as
// exactly nine digits, and drop_lead drops the top limb's first digit. an
// item with number_empty prints one '0'. first_limb or number_empty restarts
// the character count and latches capacity; characters past it are dropped,
// so an item may give no transfer at all. last_of_item marks the final
// character an item produces. the front takes a limb, splits it with
// nine divide-by-ten steps on a single reciprocal multiplier (one digit
// each) and hands it to a two-entry queue; it takes no new limb until that
// one is pushed. the back prints one character per cycle within an item
// while the output is ready, and meanwhile the front converts the next limb
module limb_to_decimal_digits (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // limb input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ldd_pkg::LIMB_W-1:0] i_limb_value,
    input  logic                      i_first_limb,
    input  logic                      i_number_empty,
    input  logic                      i_drop_lead,
    input  logic [ldd_pkg::CAP_W-1:0] i_capacity,
    // character output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ldd_pkg::CHAR_W-1:0] o_digit_char,
    output logic                      o_last_of_item
);
    import ldd_pkg::*;

    // front to queue
    logic w_push_valid, w_push_ready;
    t_job w_push_job;
    // queue to back
    logic w_pop_valid, w_pop_ready;
    t_job w_pop_job;

    // front: takes a limb, splits it into digits, works out the first digit
    ldd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_limb_value   (i_limb_value),
        .i_first_limb   (i_first_limb),
        .i_number_empty (i_number_empty),
        .i_drop_lead    (i_drop_lead),
        .i_capacity     (i_capacity),
        .o_push_valid   (w_push_valid),
        .i_push_ready   (w_push_ready),
        .o_push_job     (w_push_job)
    );

    // short queue so front and back stall independently
    ldd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    // back: keeps the count and capacity, emits characters
    ldd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (w_pop_valid),
        .o_pop_ready    (w_pop_ready),
        .i_pop_job      (w_pop_job),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_char   (o_digit_char),
        .o_last_of_item (o_last_of_item)
    );

endmodule

### test/limb_to_decimal_digits_tb.sv
module limb_to_decimal_digits_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ldd_pkg::*;

    // one limb as offered on the input channel
    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic              first;
        logic              empty;
        logic              drop;
        logic [CAP_W-1:0]  cap;
    } t_limb_item;

    // one character the printer is expected to produce
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit_char;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [LIMB_W-1:0]   i_limb_value = '0;
    logic                i_first_limb = 1'b0;
    logic                i_number_empty = 1'b0;
    logic                i_drop_lead = 1'b0;
    logic [CAP_W-1:0]    i_capacity = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [CHAR_W-1:0]   o_digit_char;
    logic                o_last_of_item;

    limb_to_decimal_digits dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_limb_value   (i_limb_value),
        .i_first_limb   (i_first_limb),
        .i_number_empty (i_number_empty),
        .i_drop_lead    (i_drop_lead),
        .i_capacity     (i_capacity),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_char   (o_digit_char),
        .o_last_of_item (o_last_of_item)
    );

    always #5 i_clk = ~i_clk;

    // limbs still to be offered, and characters still owed by the block
    t_limb_item  limb_queue[$];
    t_digit_char pending_chars[$];

    // predicted printer state: characters so far in this number, latched limit
    logic [CNT_W-1:0] pred_count = '0;
    logic [CAP_W-1:0] pred_cap = '0;

    int  limbs_total = 0;
    int  limbs_taken = 0;
    int  errors = 0;
    int  cycle = 0;
    int  pace = 1;       // 0: no idling, 1: frequent bursts, 2: rare bursts
    bit  quiet = 1'b0;   // set for the tail of the run, no idling at all
    bit  in_took = 1'b0; // input transfer seen at the last rising edge
    int  in_idle = 0;
    int  out_idle = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void emit_digit(int unsigned dig);
        t_digit_char c;
        // characters past the latched limit vanish without a trace
        if (pred_count < CNT_W'(pred_cap)) begin
            c.ch   = ASCII_ZERO + CHAR_W'(dig);
            c.last = 1'b0;
            pending_chars.push_back(c);
            pred_count = pred_count + 1'b1;
        end
    endfunction

    function automatic void predict_digit_chars(t_limb_item it);
        longint unsigned rest;
        int unsigned     dig[LIMB_DIGITS];
        int              start;
        int              before_n;
        before_n = pending_chars.size();
        // a new number restarts the count and latches the clamped limit
        if (it.first || it.empty) begin
            pred_count = '0;
            pred_cap   = (it.cap > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : it.cap;
        end
        if (it.empty) begin
            // empty number: a lone zero, limb and fraction flag ignored
            emit_digit(0);
        end else begin
            // only the low nine decimal digits of an oversized limb survive
            rest = longint'(it.limb) % 64'd1_000_000_000;
            for (int k = LIMB_DIGITS - 1; k >= 0; k--) begin
                dig[k] = int'(rest % 10);
                rest   = rest / 10;
            end
            start = 0;
            if (it.first) begin
                // top limb: strip leading zeros but keep at least one digit
                while (start < LIMB_DIGITS - 1 && dig[start] == 0)
                    start++;
                // fraction mode drops the sentinel digit
                if (it.drop)
                    start++;
            end
            for (int k = start; k < LIMB_DIGITS; k++)
                emit_digit(dig[k]);
        end
        if (pending_chars.size() > before_n)
            pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void add_limb(logic [LIMB_W-1:0] limb, bit first, bit empty,
                                     bit drop, logic [CAP_W-1:0] cap);
        t_limb_item it;
        it.limb  = limb;
        it.first = first;
        it.empty = empty;
        it.drop  = drop;
        it.cap   = cap;
        limb_queue.push_back(it);
    endfunction

    function automatic logic [LIMB_W-1:0] random_limb();
        int unsigned p10;
        case ($urandom_range(0, 5))
            0: return LIMB_W'($urandom);                    // any 30-bit value
            1: return LIMB_W'($urandom_range(0, 99));       // many leading zeros
            2: begin
                p10 = 1;
                repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                return LIMB_W'(p10);
            end
            3: return LIMB_W'($urandom_range(1_000_000_000, 1_073_741_823));
            default: return LIMB_W'($urandom_range(0, 999_999_999));
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] random_cap();
        // small limits hit truncation inside a number, large ones let it run
        if ($urandom_range(0, 3) == 0)
            return CAP_W'($urandom_range(0, 24));
        return CAP_W'($urandom);
    endfunction

    function automatic void build_stimulus();
        int later;
        // limb ahead of any number: limit is zero after reset, nothing printed
        add_limb(LIMB_W'(123456789), 0, 0, 1, CAP_W'(4095));
        // empty number with no room, then with room and junk in the limb
        add_limb(LIMB_W'(30'h3FFF_FFFF), 0, 1, 1, CAP_W'(0));
        add_limb(LIMB_W'(30'h3FFF_FFFF), 0, 1, 1, CAP_W'(4095));
        // zero top limb prints one zero, in fraction mode nothing
        add_limb(LIMB_W'(0), 1, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(0), 1, 0, 1, CAP_W'(4095));
        // later limbs are padded to nine digits, oversized ones reduced
        add_limb(LIMB_W'(0), 0, 0, 0, CAP_W'(0));
        add_limb(LIMB_W'(999_999_999), 0, 0, 0, CAP_W'(0));
        add_limb(LIMB_W'(30'h3FFF_FFFF), 0, 0, 1, CAP_W'(0));
        // oversized and largest top limbs
        add_limb(LIMB_W'(30'h3FFF_FFFF), 1, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(1_000_000_000), 1, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(999_999_999), 1, 0, 1, CAP_W'(4095));
        // a sentinel-only top limb vanishes in fraction mode
        add_limb(LIMB_W'(1), 1, 0, 1, CAP_W'(4095));
        add_limb(LIMB_W'(5), 0, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(7), 1, 0, 0, CAP_W'(4095));
        // limit reached mid limb, then a whole limb dropped
        add_limb(LIMB_W'(123_456_789), 1, 0, 0, CAP_W'(5));
        add_limb(LIMB_W'(111_111_111), 0, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(42), 1, 0, 0, CAP_W'(4));
        add_limb(LIMB_W'(987_654_321), 0, 0, 0, CAP_W'(4095));
        // empty flag together with first, limit of one, then a starved limb
        add_limb(LIMB_W'(55), 1, 1, 0, CAP_W'(1));
        add_limb(LIMB_W'(314_159_265), 0, 0, 0, CAP_W'(4095));
        // fraction flag on a later limb is ignored
        add_limb(LIMB_W'(500_000_000), 1, 0, 0, CAP_W'(4095));
        add_limb(LIMB_W'(123), 0, 0, 1, CAP_W'(0));

        // random numbers: a top limb and a run of later limbs, with some noise
        while (limb_queue.size() < 460) begin
            case ($urandom_range(0, 19))
                0, 1: add_limb(random_limb(), $urandom_range(0, 1), 1, $urandom_range(0, 1),
                               random_cap());
                2: add_limb(random_limb(), 0, 0, $urandom_range(0, 1), random_cap());
                default: begin
                    add_limb(random_limb(), 1, 0, $urandom_range(0, 1), random_cap());
                    later = $urandom_range(0, 6);
                    repeat (later)
                        add_limb(random_limb(), 0, 0, $urandom_range(0, 1), random_cap());
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------

    function automatic bit start_burst();
        if (quiet || pace == 0)
            return 1'b0;
        return $urandom_range(0, (pace == 1) ? 3 : 11) == 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers limbs at the falling edge, holds them until transfer
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : drive_limbs
        t_limb_item nxt;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (in_idle > 0) begin
                in_idle = in_idle - 1;
                i_in_valid <= 1'b0;
            end else if (start_burst()) begin
                // idle this cycle, then as many more as the draw into in_idle says
                in_idle = $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (limb_queue.size() > 0) begin
                nxt = limb_queue.pop_front();
                i_limb_value   <= nxt.limb;
                i_first_limb   <= nxt.first;
                i_number_empty <= nxt.empty;
                i_drop_lead    <= nxt.drop;
                i_capacity     <= nxt.cap;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // character sink: ready with random stall bursts
    always @(negedge i_clk) begin
        if (out_idle > 0) begin
            out_idle = out_idle - 1;
            i_out_ready <= 1'b0;
        end else if (start_burst()) begin
            out_idle = $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each limb transfer, checks each character transfer
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : watch_channels
        t_limb_item  seen;
        t_digit_char want;
        cycle = cycle + 1;
        // change the idling mix now and then
        if (cycle % 200 == 0)
            pace = $urandom_range(0, 2);
        if (!i_rst_n) begin
            in_took = 1'b0;
        end else begin
            in_took = i_in_valid && o_in_ready;
            if (in_took) begin
                seen.limb  = i_limb_value;
                seen.first = i_first_limb;
                seen.empty = i_number_empty;
                seen.drop  = i_drop_lead;
                seen.cap   = i_capacity;
                predict_digit_chars(seen);
                limbs_taken = limbs_taken + 1;
                // last stretch of the run goes without idling
                if (limbs_total > 0 && limbs_taken * 8 > limbs_total * 7)
                    quiet = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_chars.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                             $realtime, o_digit_char, o_last_of_item);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_digit_char !== want.ch) begin
                        errors = errors + 1;
                        $display("%0t: digit_char: expected %0d, actual %0d",
                                 $realtime, want.ch, o_digit_char);
                    end
                    if (o_last_of_item !== want.last) begin
                        errors = errors + 1;
                        $display("%0t: last_of_item: expected %0b, actual %0b",
                                 $realtime, want.last, o_last_of_item);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, run all limbs, drain, verdict
    // ------------------------------------------------------------------

    initial begin
        build_stimulus();
        limbs_total = limb_queue.size();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // every limb taken and every owed character seen
        while (limbs_taken < limbs_total || pending_chars.size() > 0)
            @(posedge i_clk);
        // room for a stray character from a late limb
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
